// ===== design/cst_pkg.sv =====
// Shared types, token codes and character helpers for the character stream tokenizer.
`default_nettype none

package cst_pkg;

    // Token kinds
    localparam logic [4:0] TK_END       = 5'd0;
    localparam logic [4:0] TK_IDENT     = 5'd1;
    localparam logic [4:0] TK_NUMBER    = 5'd2;
    localparam logic [4:0] TK_TRUE      = 5'd3;
    localparam logic [4:0] TK_FALSE     = 5'd4;
    localparam logic [4:0] TK_NULL      = 5'd5;
    localparam logic [4:0] TK_PROGRAM   = 5'd6;
    localparam logic [4:0] TK_LPAREN    = 5'd7;
    localparam logic [4:0] TK_RPAREN    = 5'd8;
    localparam logic [4:0] TK_LBRACE    = 5'd9;
    localparam logic [4:0] TK_RBRACE    = 5'd10;
    localparam logic [4:0] TK_LBRACKET  = 5'd11;
    localparam logic [4:0] TK_RBRACKET  = 5'd12;
    localparam logic [4:0] TK_COMMA     = 5'd13;
    localparam logic [4:0] TK_DOT       = 5'd14;
    localparam logic [4:0] TK_SEMICOLON = 5'd15;
    localparam logic [4:0] TK_MINUS     = 5'd16;
    localparam logic [4:0] TK_PLUS      = 5'd17;
    localparam logic [4:0] TK_SLASH     = 5'd18;
    localparam logic [4:0] TK_STAR      = 5'd19;
    localparam logic [4:0] TK_PERCENT   = 5'd20;
    localparam logic [4:0] TK_ASSIGN    = 5'd21;
    localparam logic [4:0] TK_EQ_EQ     = 5'd22;
    localparam logic [4:0] TK_BANG      = 5'd23;
    localparam logic [4:0] TK_BANG_EQ   = 5'd24;
    localparam logic [4:0] TK_LESS      = 5'd25;
    localparam logic [4:0] TK_LESS_EQ   = 5'd26;
    localparam logic [4:0] TK_GREATER   = 5'd27;
    localparam logic [4:0] TK_GREATER_EQ = 5'd28;
    localparam logic [4:0] TK_OR_OR     = 5'd29;
    localparam logic [4:0] TK_AND_AND   = 5'd30;
    localparam logic [4:0] TK_ERROR     = 5'd31;

    // Character codes without a printable literal
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Keyword slots
    localparam logic [1:0] KW_TRUE    = 2'd0;
    localparam logic [1:0] KW_FALSE   = 2'd1;
    localparam logic [1:0] KW_NULL    = 2'd2;
    localparam logic [1:0] KW_PROGRAM = 2'd3;
    localparam int KW_COUNT = 4;

    // Result queue sizing
    localparam int MAX_RESULTS     = 3;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_LEVEL_BITS = FIFO_PTR_BITS + 1;
    localparam int COMMIT_BITS     = FIFO_LEVEL_BITS + 1;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EQ,
        MODE_BANG,
        MODE_LESS,
        MODE_GREATER,
        MODE_OR,
        MODE_AND,
        MODE_ERROR
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] token_len;
        logic [15:0] line_no;
        logic        last;
    } token_t;

    // Tokens produced by one character, handed to the result queue
    typedef struct packed {
        logic [1:0]         count;
        token_t [MAX_RESULTS-1:0] tok;
    } scan_push_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic token_t form_token(input logic [4:0] kind, input logic [15:0] start,
                                          input logic [15:0] len, input logic [15:0] line);
        token_t t;
        t.token_kind = kind;
        t.start_pos  = start;
        t.token_len  = len;
        t.line_no    = line;
        t.last       = 1'b0;
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            KW_TRUE:    len = 3'd4;
            KW_FALSE:   len = 3'd5;
            KW_NULL:    len = 3'd4;
            KW_PROGRAM: len = 3'd7;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_TRUE:
            begin
                case (idx)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE:
            begin
                case (idx)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                case (idx)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
            KW_PROGRAM:
            begin
                case (idx)
                    3'd0:    c = "p";
                    3'd1:    c = "r";
                    3'd2:    c = "o";
                    3'd3:    c = "g";
                    3'd4:    c = "r";
                    3'd5:    c = "a";
                    3'd6:    c = "m";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Keywords that still agree with the identifier after character c at index i
    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [15:0] i, input logic [7:0] c);
        logic [KW_COUNT-1:0] keep;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            keep[k] = (i < 16'(kw_len(2'(k)))) && (kw_char(2'(k), i[2:0]) == c);
        end
        return keep;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [KW_COUNT-1:0] cand,
                                              input logic [15:0] len);
        logic [4:0] kind;
        kind = TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (cand[k] && (len == 16'(kw_len(2'(k)))))
            begin
                kind = TK_TRUE + 5'(k);
            end
        end
        return kind;
    endfunction

    // Single punctuation; TK_END means the character is not one
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] kind;
        case (c)
            "(":     kind = TK_LPAREN;
            ")":     kind = TK_RPAREN;
            "{":     kind = TK_LBRACE;
            "}":     kind = TK_RBRACE;
            "[":     kind = TK_LBRACKET;
            "]":     kind = TK_RBRACKET;
            ",":     kind = TK_COMMA;
            ".":     kind = TK_DOT;
            ";":     kind = TK_SEMICOLON;
            "-":     kind = TK_MINUS;
            "+":     kind = TK_PLUS;
            "/":     kind = TK_SLASH;
            "*":     kind = TK_STAR;
            "%":     kind = TK_PERCENT;
            default: kind = TK_END;
        endcase
        return kind;
    endfunction

    // Operator that may take a second character; MODE_IDLE means none
    function automatic scan_mode_t op_mode(input logic [7:0] c);
        scan_mode_t m;
        case (c)
            "=":     m = MODE_EQ;
            "!":     m = MODE_BANG;
            "<":     m = MODE_LESS;
            ">":     m = MODE_GREATER;
            "|":     m = MODE_OR;
            "&":     m = MODE_AND;
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] single_kind(input scan_mode_t m);
        logic [4:0] kind;
        case (m)
            MODE_EQ:      kind = TK_ASSIGN;
            MODE_BANG:    kind = TK_BANG;
            MODE_LESS:    kind = TK_LESS;
            MODE_GREATER: kind = TK_GREATER;
            default:      kind = TK_ERROR;
        endcase
        return kind;
    endfunction

    function automatic logic [4:0] pair_kind(input scan_mode_t m);
        logic [4:0] kind;
        case (m)
            MODE_EQ:      kind = TK_EQ_EQ;
            MODE_BANG:    kind = TK_BANG_EQ;
            MODE_LESS:    kind = TK_LESS_EQ;
            MODE_GREATER: kind = TK_GREATER_EQ;
            MODE_OR:      kind = TK_OR_OR;
            MODE_AND:     kind = TK_AND_AND;
            default:      kind = TK_ERROR;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== design/cst_if.sv =====
// Valid/ready channel interfaces for characters in and tokens out.
`default_nettype none

interface cst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface cst_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [15:0] line_no;
    logic        last;

    modport source (output valid, output token_kind, output start_pos, output token_len,
                    output line_no, output last, input ready);
    modport sink (input valid, input token_kind, input start_pos, input token_len,
                  input line_no, input last, output ready);
endinterface

`default_nettype wire

// ===== design/char_stream_tokenizer.sv =====
// Top level of the character stream tokenizer.
//
// Takes one source byte (or an end-of-text mark) per transaction and returns the tokens it
// completes: kind, start offset, length and starting line, with last set on the final token
// of each input transaction. An input transaction is taken every cycle while the eight-entry
// token queue has room for the tokens of the character in the input register plus the worst
// case of three from the new one; tokens are decoded from the input register and written to
// the queue, whose head drives the output. The output delivers one token per cycle while the
// receiver is ready, so a character that completes two or three tokens (a number ending in
// a dot, an end-of-text flush) takes that many transfers; input pauses only when room is short.
// POS_BITS sets the width of the offset counter; offsets wrap at 2^POS_BITS and are shown
// in sixteen bits.
`default_nettype none

module char_stream_tokenizer import cst_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cst_char_if.sink    chars,
    cst_token_if.source tokens
);

    scan_push_t                 push;
    token_t                     head;
    logic                       head_valid;
    logic [FIFO_LEVEL_BITS-1:0] level;
    logic [COMMIT_BITS-1:0]     committed;
    logic                       in_fire;
    logic                       out_fire;

    // Accept while the queue can absorb the staged and the new transaction
    assign committed    = COMMIT_BITS'(level) + COMMIT_BITS'(push.count);
    assign chars.ready  = (committed <= COMMIT_BITS'(FIFO_DEPTH - MAX_RESULTS));
    assign in_fire      = chars.valid && chars.ready;
    assign out_fire     = tokens.valid && tokens.ready;

    cst_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_fire),
        .ch          (chars.ch),
        .end_of_text (chars.end_of_text),
        .push        (push)
    );

    cst_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_fire),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    // Drive the token channel from the queue head
    assign tokens.valid      = head_valid;
    assign tokens.token_kind = head.token_kind;
    assign tokens.start_pos  = head.start_pos;
    assign tokens.token_len  = head.token_len;
    assign tokens.line_no    = head.line_no;
    assign tokens.last       = head.last;

endmodule

`default_nettype wire

// ===== design/cst_scan.sv =====
// Scanner core: input register, scan state and per-character token decode.
`default_nettype none

module cst_scan import cst_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output scan_push_t      push
);

    // Input register
    logic       stage_valid_reg;
    logic [7:0] ch_reg;
    logic       eot_reg;

    // Scan state
    scan_mode_t          mode_reg, mode_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [15:0]         len_reg, len_next;
    logic [KW_COUNT-1:0] kw_reg, kw_next;
    logic [15:0]         line_reg, line_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [15:0]         tline_reg, tline_next;

    // Decode
    logic                ch_alpha, ch_digit, ch_space, ch_newline, ch_other;
    logic [7:0]          ch_lower;
    logic [4:0]          ch_punct;
    scan_mode_t          ch_op;
    logic                extend, live, flush, fresh;
    logic [POS_BITS-1:0] dot_pos;

    logic [1:0]                n;
    token_t [MAX_RESULTS-1:0]  res;

    // Capture the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch;
            eot_reg <= end_of_text;
        end
    end

    // Classify the staged character and decide what happens to the pending token
    always_comb
    begin
        ch_lower   = ch_reg | 8'h20;
        ch_alpha   = (ch_lower inside {["a":"z"]}) || (ch_reg == "_");
        ch_digit   = ch_reg inside {["0":"9"]};
        ch_space   = ch_reg inside {" ", CH_TAB, CH_CR};
        ch_newline = (ch_reg == CH_LF);
        ch_punct   = punct_kind(ch_reg);
        ch_op      = op_mode(ch_reg);
        ch_other   = !ch_alpha && !ch_digit && !ch_space && !ch_newline
                     && (ch_punct == TK_END) && (ch_op == MODE_IDLE);

        case (mode_reg)
            MODE_IDENT:   extend = ch_alpha || ch_digit;
            MODE_INT:     extend = ch_digit || (ch_reg == ".");
            MODE_DOT:     extend = ch_digit;
            MODE_FRAC:    extend = ch_digit;
            MODE_EQ:      extend = (ch_reg == "=");
            MODE_BANG:    extend = (ch_reg == "=");
            MODE_LESS:    extend = (ch_reg == "=");
            MODE_GREATER: extend = (ch_reg == "=");
            MODE_OR:      extend = (ch_reg == "|");
            MODE_AND:     extend = (ch_reg == "&");
            default:      extend = 1'b0;
        endcase

        live  = stage_valid_reg && !eot_reg && (mode_reg != MODE_ERROR);
        flush = stage_valid_reg
                && (eot_reg || (live && (mode_reg != MODE_IDLE) && !extend));
        fresh = live && ((mode_reg == MODE_IDLE)
                || (!extend && (mode_reg != MODE_OR) && (mode_reg != MODE_AND)));

        dot_pos = start_reg + POS_BITS'(len_reg);
    end

    // Next state
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;
        tline_next = tline_reg;

        if (live)
        begin
            pos_next = pos_reg + POS_BITS'(1);
        end

        // Grow the pending token or close a two-character operator
        if (live && extend)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    kw_next  = kw_reg & kw_keep(len_reg, ch_reg);
                    len_next = sat_inc(len_reg);
                end
                MODE_INT:
                begin
                    if (ch_digit)
                    begin
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        mode_next = MODE_DOT;
                    end
                end
                MODE_DOT:
                begin
                    len_next  = sat_inc(sat_inc(len_reg));
                    mode_next = MODE_FRAC;
                end
                MODE_FRAC:
                begin
                    len_next = sat_inc(len_reg);
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        // A lone bar or ampersand drops into error mode
        if (flush)
        begin
            if ((mode_reg == MODE_OR) || (mode_reg == MODE_AND))
            begin
                mode_next = MODE_ERROR;
            end
            else if (mode_reg != MODE_ERROR)
            begin
                mode_next = MODE_IDLE;
            end
        end

        // Start scanning the character from idle
        if (fresh)
        begin
            if (ch_newline)
            begin
                line_next = sat_inc(line_reg);
            end
            else if (ch_alpha || ch_digit || (ch_op != MODE_IDLE))
            begin
                start_next = pos_reg;
                len_next   = 16'd1;
                tline_next = line_reg;
                if (ch_alpha)
                begin
                    mode_next = MODE_IDENT;
                    kw_next   = kw_keep(16'd0, ch_reg);
                end
                else if (ch_digit)
                begin
                    mode_next = MODE_INT;
                end
                else
                begin
                    mode_next = ch_op;
                end
            end
            else if (ch_other)
            begin
                mode_next = MODE_ERROR;
            end
        end

        // End of text restarts the scanner
        if (stage_valid_reg && eot_reg)
        begin
            mode_next  = MODE_IDLE;
            start_next = '0;
            len_next   = 16'd0;
            kw_next    = '1;
            line_next  = 16'd1;
            pos_next   = '0;
            tline_next = 16'd1;
        end
    end

    // Tokens caused by the staged character
    always_comb
    begin
        n   = 2'd0;
        res = '0;

        if (flush)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    res[n] = form_token(ident_kind(kw_reg, len_reg), 16'(start_reg),
                                        len_reg, tline_reg);
                    n = n + 2'd1;
                end
                MODE_INT, MODE_FRAC:
                begin
                    res[n] = form_token(TK_NUMBER, 16'(start_reg), len_reg, tline_reg);
                    n = n + 2'd1;
                end
                MODE_DOT:
                begin
                    res[n] = form_token(TK_NUMBER, 16'(start_reg), len_reg, tline_reg);
                    n = n + 2'd1;
                    res[n] = form_token(TK_DOT, 16'(dot_pos), 16'd1, tline_reg);
                    n = n + 2'd1;
                end
                MODE_EQ, MODE_BANG, MODE_LESS, MODE_GREATER:
                begin
                    res[n] = form_token(single_kind(mode_reg), 16'(start_reg), 16'd1,
                                        tline_reg);
                    n = n + 2'd1;
                end
                MODE_OR, MODE_AND:
                begin
                    res[n] = form_token(TK_ERROR, 16'(start_reg), 16'd1, tline_reg);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
        end

        // Two-character operators
        if (live && extend && (mode_reg inside {MODE_EQ, MODE_BANG, MODE_LESS, MODE_GREATER,
                                                MODE_OR, MODE_AND}))
        begin
            res[n] = form_token(pair_kind(mode_reg), 16'(start_reg), 16'd2, tline_reg);
            n = n + 2'd1;
        end

        if (fresh)
        begin
            if (ch_punct != TK_END)
            begin
                res[n] = form_token(ch_punct, 16'(pos_reg), 16'd1, line_reg);
                n = n + 2'd1;
            end
            else if (ch_other)
            begin
                res[n] = form_token(TK_ERROR, 16'(pos_reg), 16'd1, line_reg);
                n = n + 2'd1;
            end
        end

        if (stage_valid_reg && eot_reg)
        begin
            res[n] = form_token(TK_END, 16'(pos_reg), 16'd0, line_reg);
            n = n + 2'd1;
        end

        // Mark the final token of this transaction
        if (n != 2'd0)
        begin
            res[n - 2'd1].last = 1'b1;
        end

        push.count = n;
        push.tok   = res;
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= 16'd0;
            kw_reg    <= '1;
            line_reg  <= 16'd1;
            pos_reg   <= '0;
            tline_reg <= 16'd1;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            tline_reg <= tline_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cst_fifo.sv =====
// Token queue: takes up to three tokens per cycle, delivers one per cycle when popped.
`default_nettype none

module cst_fifo import cst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scan_push_t            push,
    input  wire logic                  pop,
    output token_t                     head,
    output logic                       head_valid,
    output logic [FIFO_LEVEL_BITS-1:0] level
);

    token_t                     mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LEVEL_BITS-1:0] level_reg, level_next;

    // Write the new tokens in order behind the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push.count)
            begin
                mem[wr_ptr_reg + FIFO_PTR_BITS'(i)] <= push.tok[i];
            end
        end
    end

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        level_next  = level_reg + FIFO_LEVEL_BITS'(push.count) - FIFO_LEVEL_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule

`default_nettype wire

// ===== design/cst_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none

module cst_checker import cst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  token_kind,
    input wire logic [15:0] start_pos,
    input wire logic [15:0] token_len,
    input wire logic [15:0] line_no,
    input wire logic        last
);

    // A stalled token holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(start_pos)
            && $stable(token_len) && $stable(line_no) && $stable(last))
    else $error("token changed while stalled");

    // END closes its transaction and has no length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == TK_END) |-> last && (token_len == 16'd0))
    else $error("END token without last or with length");

    // Lines count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_no != 16'd0))
    else $error("line number zero");

    // Errors cover exactly one character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == TK_ERROR) |-> (token_len == 16'd1))
    else $error("error token length not one");

    // Two-character operators are two long
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((token_kind == TK_EQ_EQ) || (token_kind == TK_BANG_EQ)
            || (token_kind == TK_LESS_EQ) || (token_kind == TK_GREATER_EQ)
            || (token_kind == TK_OR_OR) || (token_kind == TK_AND_AND))
        |-> (token_len == 16'd2))
    else $error("two-character operator with wrong length");

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .token_kind (tokens.token_kind),
    .start_pos  (tokens.start_pos),
    .token_len  (tokens.token_len),
    .line_no    (tokens.line_no),
    .last       (tokens.last)
);

`default_nettype wire

// ===== dv/char_stream_tokenizer_test.sv =====
// Self-checking testbench for the character stream tokenizer: scoreboard against a token predictor.
`timescale 1ns / 1ps

module char_stream_tokenizer_test;
    import cst_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    cst_char_if  chars_if();
    cst_token_if tokens_if();

    char_stream_tokenizer #(.POS_BITS(16)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    always #2 clk = ~clk;

    // Keyword spellings and the token kinds they map to
    string      kw_word  [KW_COUNT] = '{"true", "false", "null", "program"};
    logic [4:0] kw_token [KW_COUNT] = '{TK_TRUE, TK_FALSE, TK_NULL, TK_PROGRAM};
    string      lead_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string      tail_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string      punct_set = "()[]{},.;-+/*%=!<>";

    // Scanner state as predicted
    scan_mode_t  mode;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] tok_line;
    logic [15:0] line_cnt;
    logic [15:0] pos_cnt;
    logic [3:0]  kw_alive;

    token_t staged[$];
    token_t expected_tokens[$];

    int  fail_count;
    int  chars_sent;
    int  live_chars;
    int  tokens_seen;
    bit  idle_on;
    bit  stall_go;
    int  stall_left;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= "a" && l <= "z") || c == "_";
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void reset_scanner();
        mode      = MODE_IDLE;
        tok_start = 16'd0;
        tok_len   = 16'd0;
        kw_alive  = 4'hF;
        line_cnt  = 16'd1;
        pos_cnt   = 16'd0;
        tok_line  = 16'd1;
    endfunction

    // Stage one token; a character never yields more than the queue limit
    function automatic void emit_token(input logic [4:0] kind, input logic [15:0] start,
                                       input logic [15:0] len, input logic [15:0] line);
        token_t t;
        if (staged.size() >= MAX_RESULTS)
            return;
        t.token_kind = kind;
        t.start_pos  = start;
        t.token_len  = len;
        t.line_no    = line;
        t.last       = 1'b0;
        staged.insert(staged.size(), t);
    endfunction

    // Drop keywords that no longer agree with the identifier
    function automatic void kw_narrow(input logic [7:0] c);
        int idx;
        idx = int'(tok_len);
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (idx >= kw_word[k].len() || kw_word[k][idx] != c)
                kw_alive[k] = 1'b0;
        end
    endfunction

    function automatic void open_token(input scan_mode_t m, input logic [15:0] p);
        mode      = m;
        tok_start = p;
        tok_len   = 16'd1;
        tok_line  = line_cnt;
    endfunction

    function automatic logic [4:0] lone_op_kind(input scan_mode_t m);
        case (m)
            MODE_EQ:      return TK_ASSIGN;
            MODE_BANG:    return TK_BANG;
            MODE_LESS:    return TK_LESS;
            default:      return TK_GREATER;
        endcase
    endfunction

    function automatic logic [4:0] paired_op_kind(input scan_mode_t m);
        case (m)
            MODE_EQ:      return TK_EQ_EQ;
            MODE_BANG:    return TK_BANG_EQ;
            MODE_LESS:    return TK_LESS_EQ;
            MODE_GREATER: return TK_GREATER_EQ;
            MODE_OR:      return TK_OR_OR;
            default:      return TK_AND_AND;
        endcase
    endfunction

    // Close the pending token when it cannot grow any further
    function automatic void flush_pending();
        logic [4:0] kind;
        case (mode)
            MODE_IDENT:
            begin
                kind = TK_IDENT;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (kw_alive[k] && int'(tok_len) == kw_word[k].len())
                        kind = kw_token[k];
                end
                emit_token(kind, tok_start, tok_len, tok_line);
            end
            MODE_INT, MODE_FRAC:
                emit_token(TK_NUMBER, tok_start, tok_len, tok_line);
            MODE_DOT:
            begin
                emit_token(TK_NUMBER, tok_start, tok_len, tok_line);
                emit_token(TK_DOT, tok_start + tok_len, 16'd1, tok_line);
            end
            MODE_EQ, MODE_BANG, MODE_LESS, MODE_GREATER:
                emit_token(lone_op_kind(mode), tok_start, 16'd1, tok_line);
            MODE_OR, MODE_AND:
            begin
                emit_token(TK_ERROR, tok_start, 16'd1, tok_line);
                mode = MODE_ERROR;
                return;
            end
            default:
                return;
        endcase
        mode = MODE_IDLE;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c, input logic [15:0] p);
        if (c == " " || c == CH_TAB || c == CH_CR)
            return;
        if (c == CH_LF)
        begin
            line_cnt = bump(line_cnt);
            return;
        end
        if (is_letter(c))
        begin
            open_token(MODE_IDENT, p);
            kw_alive = 4'hF;
            tok_len  = 16'd0;
            kw_narrow(c);
            tok_len  = 16'd1;
            return;
        end
        if (is_num(c))
        begin
            open_token(MODE_INT, p);
            return;
        end
        case (c)
            "(": emit_token(TK_LPAREN, p, 16'd1, line_cnt);
            ")": emit_token(TK_RPAREN, p, 16'd1, line_cnt);
            "{": emit_token(TK_LBRACE, p, 16'd1, line_cnt);
            "}": emit_token(TK_RBRACE, p, 16'd1, line_cnt);
            "[": emit_token(TK_LBRACKET, p, 16'd1, line_cnt);
            "]": emit_token(TK_RBRACKET, p, 16'd1, line_cnt);
            ",": emit_token(TK_COMMA, p, 16'd1, line_cnt);
            ".": emit_token(TK_DOT, p, 16'd1, line_cnt);
            ";": emit_token(TK_SEMICOLON, p, 16'd1, line_cnt);
            "-": emit_token(TK_MINUS, p, 16'd1, line_cnt);
            "+": emit_token(TK_PLUS, p, 16'd1, line_cnt);
            "/": emit_token(TK_SLASH, p, 16'd1, line_cnt);
            "*": emit_token(TK_STAR, p, 16'd1, line_cnt);
            "%": emit_token(TK_PERCENT, p, 16'd1, line_cnt);
            "=": open_token(MODE_EQ, p);
            "!": open_token(MODE_BANG, p);
            "<": open_token(MODE_LESS, p);
            ">": open_token(MODE_GREATER, p);
            "|": open_token(MODE_OR, p);
            "&": open_token(MODE_AND, p);
            default:
            begin
                emit_token(TK_ERROR, p, 16'd1, line_cnt);
                mode = MODE_ERROR;
            end
        endcase
    endfunction

    function automatic void scan_next(input logic [7:0] c, input logic [15:0] p);
        case (mode)
            MODE_IDLE:
            begin
                scan_fresh(c, p);
                return;
            end
            MODE_IDENT:
                if (is_letter(c) || is_num(c))
                begin
                    kw_narrow(c);
                    tok_len = bump(tok_len);
                    return;
                end
            MODE_INT:
            begin
                if (is_num(c))
                begin
                    tok_len = bump(tok_len);
                    return;
                end
                if (c == ".")
                begin
                    mode = MODE_DOT;
                    return;
                end
            end
            MODE_DOT:
                if (is_num(c))
                begin
                    tok_len = bump(bump(tok_len));
                    mode    = MODE_FRAC;
                    return;
                end
            MODE_FRAC:
                if (is_num(c))
                begin
                    tok_len = bump(tok_len);
                    return;
                end
            MODE_EQ, MODE_BANG, MODE_LESS, MODE_GREATER:
                if (c == "=")
                begin
                    emit_token(paired_op_kind(mode), tok_start, 16'd2, tok_line);
                    mode = MODE_IDLE;
                    return;
                end
            MODE_OR, MODE_AND:
                if ((mode == MODE_OR && c == "|") || (mode == MODE_AND && c == "&"))
                begin
                    emit_token(paired_op_kind(mode), tok_start, 16'd2, tok_line);
                    mode = MODE_IDLE;
                    return;
                end
            default:
                return;
        endcase
        flush_pending();
        if (mode == MODE_IDLE)
            scan_fresh(c, p);
    endfunction

    // Work out the tokens one accepted character produces and queue them
    function automatic void predict_tokens(input logic [7:0] c, input logic eot);
        logic [15:0] p;
        staged.delete();
        if (eot)
        begin
            flush_pending();
            emit_token(TK_END, pos_cnt, 16'd0, line_cnt);
            reset_scanner();
        end
        else if (mode != MODE_ERROR)
        begin
            p = pos_cnt;
            scan_next(c, p);
            pos_cnt = p + 16'd1;
        end
        if (staged.size() > 0)
            staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i])
            expected_tokens.insert(expected_tokens.size(), staged[i]);
    endfunction

    // Offer one character transaction, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (idle_on && $urandom_range(99) < 27)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid       <= 1'b1;
        chars_if.ch          <= c;
        chars_if.end_of_text <= eot;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        if (eot || mode != MODE_ERROR)
            live_chars++;
        chars_sent++;
        predict_tokens(c, eot);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_eot();
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // Keyword, paired comparison and a fractional number
    task automatic test_keyword_and_number();
        send_text("true<=12.5");
        send_eot();
    endtask

    // Dot without a digit after it, and a two-token flush ahead of END on end of text
    task automatic test_dangling_dot();
        send_text("7.)9.");
        send_eot();
    endtask

    // New line, then a lone bar that sends the scanner into error mode
    task automatic test_lone_bar();
        send_char("x", 1'b0);
        send_char(CH_LF, 1'b0);
        send_text("|y&");
        send_eot();
    endtask

    // Null byte and bytes above 127 are unexpected characters
    task automatic test_bad_bytes();
        send_char(8'h00, 1'b0);
        send_eot();
        send_text("a");
        send_char(8'hFF, 1'b0);
        send_char("b", 1'b0);
        send_eot();
    endtask

    // Hold the token side off while characters keep arriving
    task automatic test_output_stall();
        idle_on  = 1'b0;
        stall_go = 1'b1;
        for (int i = 0; i < 40; i++)
            send_char(punct_set[$urandom_range(13)], 1'b0);
        send_eot();
        idle_on = 1'b1;
    endtask

    task automatic send_random_lexeme();
        string word;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // identifier, often a keyword or something close to one
            if ($urandom_range(2) == 0)
            begin
                word = kw_word[$urandom_range(KW_COUNT - 1)];
                case ($urandom_range(2))
                    0: word = word.substr(0, word.len() - 2);
                    1: word = {word, "_"};
                    default: ;
                endcase
            end
            else
            begin
                word = "";
                word = {word, string'(lead_set[$urandom_range(lead_set.len() - 1)])};
                repeat ($urandom_range(6))
                    word = {word, string'(tail_set[$urandom_range(tail_set.len() - 1)])};
            end
            send_text(word);
        end
        else if (pick < 43)
        begin
            // number, with an optional fraction or a dangling dot
            repeat ($urandom_range(1, 4))
                send_char(8'("0" + $urandom_range(9)), 1'b0);
            if ($urandom_range(3) == 0)
                send_char(".", 1'b0);
            else if ($urandom_range(1) == 0)
            begin
                send_char(".", 1'b0);
                repeat ($urandom_range(1, 3))
                    send_char(8'("0" + $urandom_range(9)), 1'b0);
            end
        end
        else if (pick < 61)
        begin
            // punctuation or an operator, optionally followed by an equals or a doubled bar or ampersand
            send_char(punct_set[$urandom_range(punct_set.len() - 1)], 1'b0);
            case ($urandom_range(3))
                0: send_char("=", 1'b0);
                1: send_text(($urandom_range(1) == 0) ? "||" : "&&");
                default: ;
            endcase
        end
        else if (pick < 81)
        begin
            case ($urandom_range(3))
                0: send_char(" ", 1'b0);
                1: send_char(CH_TAB, 1'b0);
                2: send_char(CH_CR, 1'b0);
                default: send_char(CH_LF, 1'b0);
            endcase
        end
        else if (pick < 93)
        begin
            // noise or a lone bar or ampersand, then a little junk and end of text
            if (pick < 89)
                send_char(8'($urandom_range(255)), 1'b0);
            else
                send_text(($urandom_range(1) == 0) ? "|" : "&");
            repeat ($urandom_range(2))
                send_char(8'($urandom_range(255)), 1'b0);
            send_eot();
        end
        else
            send_eot();
    endtask

    task automatic test_random_text(input int target, input bit with_idle);
        int start_count;
        idle_on     = with_idle;
        start_count = live_chars;
        while (live_chars - start_count < target)
            send_random_lexeme();
        send_eot();
        idle_on = 1'b1;
    endtask

    // Token side: random back-pressure, plus a long hold when asked
    always @(posedge clk)
    begin
        if (stall_go)
        begin
            stall_left = 90;
            stall_go   = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            tokens_if.ready <= 1'b0;
        end
        else
            tokens_if.ready <= !(idle_on && $urandom_range(99) < 27);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each token transaction with the oldest prediction
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && tokens_if.valid && tokens_if.ready)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d at %0d", tokens_if.token_kind,
                       tokens_if.start_pos);
                fail_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 16'(want.token_kind), 16'(tokens_if.token_kind));
                check_field("start_pos", want.start_pos, tokens_if.start_pos);
                check_field("token_len", want.token_len, tokens_if.token_len);
                check_field("line_no", want.line_no, tokens_if.line_no);
                check_field("last", 16'(want.last), 16'(tokens_if.last));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("** char_stream_tokenizer: FAILED **");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n                = 1'b0;
        chars_if.valid       = 1'b0;
        chars_if.ch          = 8'h00;
        chars_if.end_of_text = 1'b0;
        tokens_if.ready      = 1'b0;
        idle_on              = 1'b1;
        stall_go             = 1'b0;
        stall_left           = 0;
        fail_count           = 0;
        chars_sent           = 0;
        live_chars           = 0;
        tokens_seen          = 0;
        reset_scanner();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keyword_and_number();
        test_dangling_dot();
        test_lone_bar();
        test_bad_bytes();
        test_output_stall();
        test_random_text(55, 1'b1);
        test_random_text(25, 1'b0);
        test_random_text(10, 1'b1);
        chars_if.valid <= 1'b0;

        // Drain the token queue, then allow for the pipeline
        waited = 0;
        while (expected_tokens.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            $error("%0d predicted tokens never arrived", expected_tokens.size());
            fail_count++;
        end

        $display("Scanned %0d characters and checked %0d tokens: keywords, numbers,",
                 chars_sent, tokens_seen);
        $display("operators, error recovery and a long hold on the token side.");
        if (fail_count == 0)
            $display("** char_stream_tokenizer: PASSED **");
        else
            $display("** char_stream_tokenizer: FAILED **");
        $finish;
    end

endmodule
